// ===== sv/hufd_pkg.sv =====
package hufd_pkg;

  localparam int SYMBOL_BITS = 8;
  localparam int OP_W        = 2;
  localparam int CODE_W      = 16;
  localparam int LEN_W       = 5;
  localparam int WIN_W       = 5;
  localparam int CNT_W       = 5;
  localparam int BUF_BITS    = 24;
  localparam int BYTE_BITS   = 8;

  localparam logic [SYMBOL_BITS-1:0] NEWLINE_SYM = 8'd10;

  // operation codes on the input channel
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_DATA  = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  // work handed from front to back
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_DATA,
    CMD_FLUSH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [SYMBOL_BITS-1:0] sym;
    logic [CODE_W-1:0]      code;
    logic [LEN_W-1:0]       len;
    logic [BYTE_BITS-1:0]   data;
  } cmd_t;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   end_of_line;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic [LEN_W-1:0]       len;
    logic [SYMBOL_BITS-1:0] sym;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FILL,
    BK_LOOKUP,
    BK_EMIT
  } back_state_t;

endpackage

// ===== sv/hufd_fifo.sv =====
module hufd_fifo #(
  parameter int WIDTH    = 8,
  parameter int PTR_BITS = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int DEPTH = 1 << PTR_BITS;

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_BITS:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == (PTR_BITS+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/hufd_front.sv =====
module hufd_front import hufd_pkg::*; (
  input  logic                   in_valid,
  input  logic [OP_W-1:0]        operation,
  input  logic [SYMBOL_BITS-1:0] symbol_value,
  input  logic [CODE_W-1:0]      code_bits,
  input  logic [LEN_W-1:0]       code_length,
  input  logic [BYTE_BITS-1:0]   data_byte,
  input  logic [WIN_W-1:0]       window,
  output logic                   cmd_push,
  output cmd_t                   cmd
);

  logic keep;

  // drop unused operation codes and loads of zero length or longer than the window
  always_comb begin
    cmd.sym  = symbol_value;
    cmd.code = code_bits;
    cmd.len  = code_length;
    cmd.data = data_byte;
    cmd.kind = CMD_FLUSH;
    keep     = 1'b0;
    unique case (op_t'(operation))
      OP_LOAD: begin
        cmd.kind = CMD_LOAD;
        keep     = (code_length != '0) && (code_length <= LEN_W'(window));
      end
      OP_DATA: begin
        cmd.kind = CMD_DATA;
        keep     = 1'b1;
      end
      OP_FLUSH: begin
        cmd.kind = CMD_FLUSH;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_push = in_valid & keep;

endmodule

// ===== sv/hufd_back.sv =====
module hufd_back import hufd_pkg::*; #(
  parameter int ADDR_BITS = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [WIN_W-1:0] window,
  input  cmd_t             cmd,
  input  logic             cmd_valid,
  output logic             cmd_pop,
  output result_t          res,
  output logic             res_push,
  input  logic             res_full
);

  localparam int SLOTS = 1 << ADDR_BITS;

  entry_t tbl_mem [SLOTS];

  back_state_t            state_r, state_nxt;
  logic [BUF_BITS-1:0]    buf_r, buf_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [ADDR_BITS-1:0]   fill_addr_r, fill_addr_nxt;
  logic [ADDR_BITS-1:0]   fill_last_r, fill_last_nxt;
  entry_t                 fill_ent_r, fill_ent_nxt;
  entry_t                 rd_ent_r;

  logic                   tbl_we, rd_en;
  logic [ADDR_BITS-1:0]   rd_idx;

  // slot range of a load
  logic [WIN_W-1:0]       shift_amt;
  logic [31:0]            code_mask32, base32, span_mask32, last32;
  logic [ADDR_BITS-1:0]   load_base, load_last;

  // lookup window and length consumed
  logic [CNT_W-1:0]       win_sh;
  logic [BUF_BITS-1:0]    win_bits;
  logic [31:0]            win_mask32;
  logic [LEN_W-1:0]       len_c;
  logic [CNT_W-1:0]       cnt_after;

  always_comb begin
    shift_amt   = window - WIN_W'(cmd.len);
    code_mask32 = (32'd1 << cmd.len) - 32'd1;
    base32      = ({16'b0, cmd.code} & code_mask32) << shift_amt;
    span_mask32 = (32'd1 << shift_amt) - 32'd1;
    last32      = base32 | span_mask32;
    load_base   = base32[ADDR_BITS-1:0];
    load_last   = last32[ADDR_BITS-1:0];
  end

  always_comb begin
    win_sh     = cnt_r - CNT_W'(window);
    win_bits   = buf_r >> win_sh;
    win_mask32 = (32'd1 << window) - 32'd1;
    rd_idx     = win_bits[ADDR_BITS-1:0] & win_mask32[ADDR_BITS-1:0];
  end

  always_comb begin
    priority if (rd_ent_r.len == '0) begin
      len_c = LEN_W'(1);
    end else if (rd_ent_r.len > LEN_W'(window)) begin
      len_c = LEN_W'(window);
    end else begin
      len_c = rd_ent_r.len;
    end
    cnt_after       = cnt_r - CNT_W'(len_c);
    res.symbol      = rd_ent_r.sym;
    res.end_of_line = (rd_ent_r.sym == NEWLINE_SYM);
    res.last        = (cnt_after < CNT_W'(window));
  end

  always_comb begin
    state_nxt     = state_r;
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    fill_addr_nxt = fill_addr_r;
    fill_last_nxt = fill_last_r;
    fill_ent_nxt  = fill_ent_r;
    cmd_pop       = 1'b0;
    tbl_we        = 1'b0;
    rd_en         = 1'b0;
    res_push      = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_LOAD: begin
              fill_addr_nxt    = load_base;
              fill_last_nxt    = load_last;
              fill_ent_nxt.len = cmd.len;
              fill_ent_nxt.sym = cmd.sym;
              state_nxt        = BK_FILL;
            end
            CMD_DATA: begin
              buf_nxt   = {buf_r[BUF_BITS-BYTE_BITS-1:0], cmd.data};
              cnt_nxt   = cnt_r + CNT_W'(BYTE_BITS);
              state_nxt = BK_LOOKUP;
            end
            CMD_FLUSH: begin
              buf_nxt = '0;
              cnt_nxt = '0;
            end
            default: begin
              state_nxt = BK_IDLE;
            end
          endcase
        end
      end
      BK_FILL: begin
        tbl_we = 1'b1;
        if (fill_addr_r == fill_last_r) begin
          state_nxt = BK_IDLE;
        end else begin
          fill_addr_nxt = fill_addr_r + 1'b1;
        end
      end
      BK_LOOKUP: begin
        if (cnt_r >= CNT_W'(window)) begin
          rd_en     = 1'b1;
          state_nxt = BK_EMIT;
        end else begin
          state_nxt = BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          cnt_nxt   = cnt_after;
          state_nxt = BK_LOOKUP;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      buf_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      buf_r   <= buf_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_addr_r <= fill_addr_nxt;
    fill_last_r <= fill_last_nxt;
    fill_ent_r  <= fill_ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[fill_addr_r] <= fill_ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ent_r <= tbl_mem[rd_idx];
    end
  end

endmodule

// ===== sv/huffman_table_decoder.sv =====
// channel  | ports                                   | accepted when
// ---------+-----------------------------------------+--------------------
// input    | in_push, in_full, in_operation, ...     | in_push & !in_full
// result   | out_empty, out_pop, out_symbol, ...     | out_pop & !out_empty
// config   | cfg_wr_en, cfg_wr_data (max_code_len)   | cfg_wr_en
//
// back end: a flush clears the bit buffer, a load writes its 2^(W-len) slots (one slot a cycle)
//   and a data byte looks up and emits each decoded symbol
// W is max_code_len clamped to 1..MAX_CODE_BITS
// reset: synchronous, active low; clears queues, bit buffer, count, max_code_len to 1
// stalls: a full result queue holds the back end in emit and a full command
//   queue raises in_full, so the two sides stall on their own
module huffman_table_decoder import hufd_pkg::*; #(
  parameter int MAX_CODE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [OP_W-1:0]        in_operation,
  input  logic [SYMBOL_BITS-1:0] in_symbol_value,
  input  logic [CODE_W-1:0]      in_code_bits,
  input  logic [LEN_W-1:0]       in_code_length,
  input  logic [BYTE_BITS-1:0]   in_data_byte,
  // result channel
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [SYMBOL_BITS-1:0] out_symbol,
  output logic                   out_end_of_line,
  output logic                   out_last,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [WIN_W-1:0]       cfg_wr_data
);

  localparam int CMD_PTR_BITS = 1;
  localparam int RES_PTR_BITS = 2;
  localparam int CMD_W        = $bits(cmd_t);
  localparam int RES_W        = $bits(result_t);

  // max_code_len register and its clamped window
  logic [WIN_W-1:0] max_code_len_r, max_code_len_nxt;
  logic [WIN_W-1:0] window;

  assign max_code_len_nxt = cfg_wr_en ? cfg_wr_data : max_code_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_code_len_r <= WIN_W'(1);
    end else begin
      max_code_len_r <= max_code_len_nxt;
    end
  end

  always_comb begin
    priority if (max_code_len_r == '0) begin
      window = WIN_W'(1);
    end else if (max_code_len_r > WIN_W'(MAX_CODE_BITS)) begin
      window = WIN_W'(MAX_CODE_BITS);
    end else begin
      window = max_code_len_r;
    end
  end

  // front: classify and drop words that do nothing
  logic             cmd_push;
  cmd_t             cmd_in;
  logic [CMD_W-1:0] cmd_in_bits, cmd_out_bits;
  cmd_t             cmd_out;
  logic             cmd_empty, cmd_pop;

  hufd_front u_front (
    .in_valid     (in_push),
    .operation    (in_operation),
    .symbol_value (in_symbol_value),
    .code_bits    (in_code_bits),
    .code_length  (in_code_length),
    .data_byte    (in_data_byte),
    .window       (window),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  assign cmd_in_bits = cmd_in;
  assign cmd_out     = cmd_t'(cmd_out_bits);

  // short command queue between front and back
  hufd_fifo #(
    .WIDTH    (CMD_W),
    .PTR_BITS (CMD_PTR_BITS)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in_bits),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_out_bits),
    .empty (cmd_empty)
  );

  // back: table fill, bit buffer and lookup loop
  result_t          res;
  logic             res_push, res_full;
  logic [RES_W-1:0] res_in_bits, res_out_bits;
  result_t          res_out;

  hufd_back #(
    .ADDR_BITS (MAX_CODE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .window    (window),
    .cmd       (cmd_out),
    .cmd_valid (~cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  assign res_in_bits = res;

  // result queue decouples the consumer from the lookup loop
  hufd_fifo #(
    .WIDTH    (RES_W),
    .PTR_BITS (RES_PTR_BITS)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in_bits),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out_bits),
    .empty (out_empty)
  );

  assign res_out         = result_t'(res_out_bits);
  assign out_symbol      = res_out.symbol;
  assign out_end_of_line = res_out.end_of_line;
  assign out_last        = res_out.last;

  // back end never writes a full result queue
  a_no_res_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // a command is taken only when idle, never while emitting
  a_pop_not_emit : assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_pop && res_push))
    else $error("command taken during emit");

  // command queue is never popped empty
  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hufd_pkg::*;

  localparam int MAX_CODE_BITS = 12;
  localparam int TBL_SLOTS = 1 << MAX_CODE_BITS;
  // one data byte never yields more symbols than this
  localparam int MAX_SYMS_PER_BYTE = 23;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int WORD_TARGET = 420;
  // the one operation code the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_push = 1'b0;
  logic                   in_full;
  logic [OP_W-1:0]        in_operation = OP_FLUSH;
  logic [SYMBOL_BITS-1:0] in_symbol_value = '0;
  logic [CODE_W-1:0]      in_code_bits = '0;
  logic [LEN_W-1:0]       in_code_length = '0;
  logic [BYTE_BITS-1:0]   in_data_byte = '0;
  logic                   out_empty;
  logic                   out_pop = 1'b0;
  logic [SYMBOL_BITS-1:0] out_symbol;
  logic                   out_end_of_line;
  logic                   out_last;
  logic                   cfg_wr_en = 1'b0;
  logic [WIN_W-1:0]       cfg_wr_data = '0;

  // shadow copy of the decoder: lookup table, bit buffer and window register
  logic [SYMBOL_BITS-1:0] tbl_sym [TBL_SLOTS];
  logic [LEN_W-1:0]       tbl_len [TBL_SLOTS];
  bit                     tbl_written [TBL_SLOTS];
  logic [BUF_BITS-1:0]    bit_buf = '0;
  int                     bit_cnt = 0;
  logic [WIN_W-1:0]       max_len_reg = 5'd1;

  // decoded symbols still owed by the block, oldest first
  result_t expected_symbols [$];

  int  errors = 0;
  int  words_sent = 0;
  int  symbols_checked = 0;
  int  settings_used = 0;
  int  cycle_count = 0;
  int  pop_hold = 0;
  // rough back end cycles queued behind the last word that produced symbols
  int  trailing_work = 0;
  bit  in_gaps_on = 1'b1;
  bit  pop_stalls_on = 1'b1;

  huffman_table_decoder #(.MAX_CODE_BITS(MAX_CODE_BITS)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_operation    (in_operation),
    .in_symbol_value (in_symbol_value),
    .in_code_bits    (in_code_bits),
    .in_code_length  (in_code_length),
    .in_data_byte    (in_data_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_symbol      (out_symbol),
    .out_end_of_line (out_end_of_line),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("huffman_table_decoder test failed");
      $finish;
    end
  end

  // effective lookup window: register clamped to 1..MAX_CODE_BITS
  function automatic int window_of(logic [WIN_W-1:0] value);
    if (value < 1) return 1;
    if (value > MAX_CODE_BITS) return MAX_CODE_BITS;
    return int'(value);
  endfunction

  // every slot a window of w bits can hit has been loaded
  function automatic bit table_covered(int w);
    for (int i = 0; i < (1 << w); i++) begin
      if (!tbl_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SYMBOL_BITS-1:0] rand_symbol();
    if ($urandom_range(0, 5) == 0) return NEWLINE_SYM;
    return SYMBOL_BITS'($urandom);
  endfunction

  // advance the shadow decoder by one accepted word, queue the symbols it yields
  task automatic decode_word(logic [OP_W-1:0] op, logic [SYMBOL_BITS-1:0] sym,
                             logic [CODE_W-1:0] code, logic [LEN_W-1:0] len,
                             logic [BYTE_BITS-1:0] data);
    int w, c, base, span, idx, used, n;
    result_t r;
    w = window_of(max_len_reg);
    case (op)
      OP_LOAD: begin
        trailing_work += 2;
        // zero length or longer than the window: dropped
        if (len >= 1 && int'(len) <= w) begin
          c = int'(code) & ((1 << int'(len)) - 1);
          base = c << (w - int'(len));
          span = 1 << (w - int'(len));
          // every slot sharing the code as its prefix
          for (int i = 0; i < span; i++) begin
            tbl_sym[base + i] = sym;
            tbl_len[base + i] = len;
            tbl_written[base + i] = 1'b1;
          end
          trailing_work += span;
          words_sent++;
        end
      end
      OP_FLUSH: begin
        bit_buf = '0;
        bit_cnt = 0;
        trailing_work += 2;
        words_sent++;
      end
      OP_DATA: begin
        bit_buf = {bit_buf[BUF_BITS-BYTE_BITS-1:0], data};
        bit_cnt = (bit_cnt + BYTE_BITS > BUF_BITS) ? BUF_BITS : bit_cnt + BYTE_BITS;
        n = 0;
        while (bit_cnt >= w && n < MAX_SYMS_PER_BYTE) begin
          idx = int'(bit_buf >> (bit_cnt - w)) & ((1 << w) - 1);
          // slot length clamped to the current window
          used = int'(tbl_len[idx]);
          if (used < 1) used = 1;
          if (used > w) used = w;
          bit_cnt -= used;
          n++;
          r.symbol = tbl_sym[idx];
          r.end_of_line = (tbl_sym[idx] == NEWLINE_SYM);
          r.last = !(bit_cnt >= w && n < MAX_SYMS_PER_BYTE);
          expected_symbols.push_back(r);
        end
        bit_buf &= BUF_BITS'((1 << bit_cnt) - 1);
        trailing_work = (n > 0) ? 0 : trailing_work + 4;
        words_sent++;
      end
      default: trailing_work += 2;  // unused code, ignored
    endcase
  endtask

  // one word over the input queue, with a random gap ahead of it
  task automatic send_word(logic [OP_W-1:0] op, logic [SYMBOL_BITS-1:0] sym,
                           logic [CODE_W-1:0] code, logic [LEN_W-1:0] len,
                           logic [BYTE_BITS-1:0] data);
    int gap;
    gap = pick_gap(in_gaps_on);
    @(negedge clk);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push         <= 1'b1;
    in_operation    <= op;
    in_symbol_value <= sym;
    in_code_bits    <= code;
    in_code_length  <= len;
    in_data_byte    <= data;
    @(posedge clk);
    while (in_full) @(posedge clk);
    decode_word(op, sym, code, len, data);
  endtask

  // code entry with junk above the code bits and in the unused byte field
  task automatic send_load(logic [SYMBOL_BITS-1:0] sym, int code, int len);
    logic [CODE_W-1:0] keep;
    keep = (len >= CODE_W) ? '1 : CODE_W'((1 << len) - 1);
    send_word(OP_LOAD, sym, (CODE_W'($urandom) & ~keep) | (CODE_W'(code) & keep),
              LEN_W'(len), BYTE_BITS'($urandom));
  endtask

  task automatic send_data(logic [BYTE_BITS-1:0] data);
    send_word(OP_DATA, SYMBOL_BITS'($urandom), CODE_W'($urandom), LEN_W'($urandom),
              data);
  endtask

  task automatic send_other(logic [OP_W-1:0] op);
    send_word(op, SYMBOL_BITS'($urandom), CODE_W'($urandom), LEN_W'($urandom),
              BYTE_BITS'($urandom));
  endtask

  // drop push, let every owed symbol drain, then cover table fills still running
  task automatic wait_idle();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (trailing_work + 64) @(posedge clk);
    trailing_work = 0;
  endtask

  task automatic write_max_code_len(logic [WIN_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    max_len_reg = value;
    settings_used++;
  endtask

  // random complete prefix code for a w bit window, loaded in random order
  task automatic load_full_code(int w);
    int leaf_code [$];
    int leaf_len [$];
    int target, pick, k, tmp;
    leaf_code.push_back(0);
    leaf_len.push_back(0);
    target = $urandom_range(2, (w >= 5) ? 24 : (1 << w));
    while (leaf_code.size() < target) begin
      // often split the newest leaf, which grows long codes
      if ($urandom_range(0, 9) < 4) pick = leaf_code.size() - 1;
      else pick = $urandom_range(0, leaf_code.size() - 1);
      while (leaf_len[pick] >= w) pick = (pick + 1) % leaf_code.size();
      leaf_code.push_back((leaf_code[pick] << 1) | 1);
      leaf_len.push_back(leaf_len[pick] + 1);
      leaf_code[pick] = leaf_code[pick] << 1;
      leaf_len[pick] += 1;
    end
    for (int j = leaf_code.size() - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      tmp = leaf_code[j]; leaf_code[j] = leaf_code[k]; leaf_code[k] = tmp;
      tmp = leaf_len[j];  leaf_len[j]  = leaf_len[k];  leaf_len[k]  = tmp;
    end
    foreach (leaf_code[j]) send_load(rand_symbol(), leaf_code[j], leaf_len[j]);
  endtask

  // window of one bit straight out of reset: both codes, ignored loads, odd op
  task automatic test_narrow_window();
    send_load(NEWLINE_SYM, 0, 1);
    send_load(8'hFF, 1, 1);
    send_load(8'h00, 0, 0);   // zero length
    send_load(8'h00, 3, 16);  // longer than the window
    send_other(OP_UNUSED);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'hA5);
    send_other(OP_FLUSH);
    send_data(8'h3C);
  endtask

  // register above the table size clamps to 12 bits; codes of every length 1..12
  task automatic test_wide_window();
    logic [SYMBOL_BITS-1:0] sym;
    write_max_code_len(5'd16);
    // 1, 01, 001, ... with two 12 bit codes closing the tree
    for (int len = 1; len <= MAX_CODE_BITS; len++) begin
      if (len == 1) sym = 8'hFF;
      else if (len == 3) sym = NEWLINE_SYM;
      else sym = SYMBOL_BITS'(len * 29);
      send_load(sym, 1, len);
    end
    send_load(8'h00, 0, MAX_CODE_BITS);
    send_data(8'h00);
    send_data(8'h00);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h01);
    send_other(OP_FLUSH);
    send_data(8'h80);
  endtask

  // narrower window over slots holding 9..12 bit codes: lengths get clamped
  task automatic test_shrunk_window();
    write_max_code_len(5'd4);
    send_data(8'h00);
    send_data(8'hF0);
    send_data(8'h0F);
    send_other(OP_FLUSH);
  endtask

  // phases of window setting, optional fresh code, then mostly random bytes
  task automatic test_random_phases();
    int phase, w, n, r;
    logic [WIN_W-1:0] value;
    phase = 0;
    while (words_sent < WORD_TARGET) begin
      case (phase)
        0: value = 5'd1;
        1: value = 5'd16;
        2: value = 5'd0;
        3: value = 5'd31;
        4: value = 5'd13;
        5: value = 5'd2;
        default: value = WIN_W'($urandom_range(1, 16));
      endcase
      in_gaps_on = ($urandom_range(0, 3) != 0);
      pop_stalls_on = ($urandom_range(0, 3) != 0);
      write_max_code_len(value);
      w = window_of(max_len_reg);
      // never let a lookup reach a slot nothing has loaded
      if (!table_covered(w) || $urandom_range(0, 2) == 0) load_full_code(w);
      n = $urandom_range(15, 45);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 76) send_data(BYTE_BITS'($urandom));
        else if (r < 82) send_other(OP_FLUSH);
        else if (r < 88) send_load(rand_symbol(), $urandom, $urandom_range(1, w));
        else if (r < 94)
          send_load(SYMBOL_BITS'($urandom), $urandom,
                    ($urandom_range(0, 3) != 0) ? $urandom_range(w + 1, 31) : 0);
        else send_other(OP_UNUSED);
      end
      phase++;
    end
  endtask

  // result side: pop with random stalls, some phases without any
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      out_pop  <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      out_pop  <= 1'b1;
      pop_hold <= pick_gap(pop_stalls_on);
    end
  end

  // compare each popped word with the oldest owed symbol
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_symbols.size() == 0) begin
        $error("symbol %0d popped with nothing owed", out_symbol);
        errors++;
      end else begin
        want = expected_symbols.pop_front();
        symbols_checked++;
        if (out_symbol !== want.symbol) begin
          $error("out_symbol expected %0d got %0d", want.symbol, out_symbol);
          errors++;
        end
        if (out_end_of_line !== want.end_of_line) begin
          $error("out_end_of_line expected %0d got %0d", want.end_of_line,
                 out_end_of_line);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("out_last expected %0d got %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_narrow_window();
    test_wide_window();
    test_shrunk_window();
    test_random_phases();
    wait_idle();
    $display("%0d words decoded or loaded over %0d window settings, %0d symbols checked",
             words_sent, settings_used, symbols_checked);
    if (errors == 0) begin
      $display("huffman_table_decoder test passed");
    end else begin
      $display("huffman_table_decoder test failed");
    end
    $finish;
  end

endmodule
